[hw/rtl/i2r_pkg.sv]
// shared types, constants and digit-pattern functions for the roman numeral encoder
// used by i2r_split, i2r_emit and integer_to_roman_numeral; no dependencies
package i2r_pkg;

   localparam int unsigned VALUE_W  = 12;
   localparam int unsigned CHAR_W   = 7;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned PLACES   = 4;
   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 8;

   localparam logic [VALUE_W-1:0] ROMAN_MAX = 12'd3999;

   // reciprocal multipliers: r*41 >> 12 is r/100 for r < 1000, r*205 >> 11 is r/10 for r < 100
   localparam logic [5:0] RECIP_100 = 6'd41;
   localparam logic [7:0] RECIP_10  = 8'd205;

   localparam logic [CHAR_W-1:0] ASCII_NUL = 7'h00;
   localparam logic [CHAR_W-1:0] ASCII_M   = 7'h4D;
   localparam logic [CHAR_W-1:0] ASCII_D   = 7'h44;
   localparam logic [CHAR_W-1:0] ASCII_C   = 7'h43;
   localparam logic [CHAR_W-1:0] ASCII_L   = 7'h4C;
   localparam logic [CHAR_W-1:0] ASCII_X   = 7'h58;
   localparam logic [CHAR_W-1:0] ASCII_V   = 7'h56;
   localparam logic [CHAR_W-1:0] ASCII_I   = 7'h49;

   localparam logic [1:0] PLACE_ONES      = 2'd0;
   localparam logic [1:0] PLACE_TENS      = 2'd1;
   localparam logic [1:0] PLACE_HUNDREDS  = 2'd2;
   localparam logic [1:0] PLACE_THOUSANDS = 2'd3;

   typedef enum logic [1:0] {
      SYM_UNIT,
      SYM_FIVE,
      SYM_TEN
   } sym_type;

   // one decimal-split item, digit[3] is the thousands digit
   typedef struct packed {
      logic                            error;
      logic [PLACES-1:0][DIGIT_W-1:0]  digit;
   } item_type;

   // number of letters a digit is written with
   function automatic logic [2:0] shape_len(input logic [DIGIT_W-1:0] d);
      logic [2:0] n;
      unique case (d)
         4'd1, 4'd5:             n = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
         4'd3, 4'd7:             n = 3'd3;
         4'd8:                   n = 3'd4;
         default:                n = 3'd0;
      endcase
      return n;
   endfunction

   // symbol at letter position j of a digit pattern
   function automatic sym_type shape_sym(input logic [DIGIT_W-1:0] d, input logic [1:0] j);
      sym_type s;
      unique case (d)
         4'd4:                s = (j == 2'd0) ? SYM_UNIT : SYM_FIVE;
         4'd5:                s = SYM_FIVE;
         4'd6, 4'd7, 4'd8:    s = (j == 2'd0) ? SYM_FIVE : SYM_UNIT;
         4'd9:                s = (j == 2'd0) ? SYM_UNIT : SYM_TEN;
         default:             s = SYM_UNIT;
      endcase
      return s;
   endfunction

   // ascii letter for a symbol at a decimal place
   function automatic logic [CHAR_W-1:0] letter(input logic [1:0] place, input sym_type s);
      logic [CHAR_W-1:0] c;
      unique case (place)
         PLACE_THOUSANDS: c = ASCII_M;
         PLACE_HUNDREDS:  c = (s == SYM_UNIT) ? ASCII_C : ((s == SYM_FIVE) ? ASCII_D : ASCII_M);
         PLACE_TENS:      c = (s == SYM_UNIT) ? ASCII_X : ((s == SYM_FIVE) ? ASCII_L : ASCII_C);
         default:         c = (s == SYM_UNIT) ? ASCII_I : ((s == SYM_FIVE) ? ASCII_V : ASCII_X);
      endcase
      return c;
   endfunction

endpackage

[hw/rtl/i2r_split.sv]
// five-stage pipeline that checks the range and splits a value into decimal digits
// depends on i2r_pkg
module i2r_split import i2r_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [VALUE_W-1:0]  in_value,
   output logic                out_valid,
   input  logic                out_ready,
   output item_type            out_item
);

   // stage valids and load enables
   logic [4:0] vld_ff, vld_in;
   logic [4:0] ld;

   // stage 1: range check, thousands digit, remainder below 1000
   logic        s1_err_ff, s1_err_in;
   logic [1:0]  s1_th_ff, s1_th_in;
   logic [9:0]  s1_rem_ff, s1_rem_in;
   logic [11:0] th_base;

   // stage 2: reciprocal product for hundreds
   logic        s2_err_ff;
   logic [1:0]  s2_th_ff;
   logic [9:0]  s2_rem_ff;
   logic [15:0] s2_prod_ff, s2_prod_in;

   // stage 3: hundreds digit, remainder below 100
   logic        s3_err_ff;
   logic [1:0]  s3_th_ff;
   logic [3:0]  s3_hu_ff;
   logic [6:0]  s3_rem_ff, s3_rem_in;
   logic [10:0] hu_base;

   // stage 4: reciprocal product for tens
   logic        s4_err_ff;
   logic [1:0]  s4_th_ff;
   logic [3:0]  s4_hu_ff;
   logic [6:0]  s4_rem_ff;
   logic [14:0] s4_prod_ff, s4_prod_in;

   // stage 5: tens and ones digits
   item_type    s5_item_ff, s5_item_in;
   logic [3:0]  te_dig;
   logic [7:0]  te_base;

   assign ld[4]    = !vld_ff[4] || out_ready;
   assign ld[3]    = !vld_ff[3] || ld[4];
   assign ld[2]    = !vld_ff[2] || ld[3];
   assign ld[1]    = !vld_ff[1] || ld[2];
   assign ld[0]    = !vld_ff[0] || ld[1];
   assign in_ready = ld[0];

   always_comb begin
      vld_in[0] = ld[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < 5; k++) begin
         vld_in[k] = ld[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_comb begin
      s1_err_in = (in_value == '0) || (in_value > ROMAN_MAX);
      priority if (in_value >= 12'd3000) begin
         s1_th_in = 2'd3;
         th_base  = 12'd3000;
      end else if (in_value >= 12'd2000) begin
         s1_th_in = 2'd2;
         th_base  = 12'd2000;
      end else if (in_value >= 12'd1000) begin
         s1_th_in = 2'd1;
         th_base  = 12'd1000;
      end else begin
         s1_th_in = 2'd0;
         th_base  = 12'd0;
      end
      s1_rem_in = s1_err_in ? 10'd0 : 10'(in_value - th_base);
   end

   assign s2_prod_in = 16'(s1_rem_ff) * 16'(RECIP_100);

   assign hu_base   = 11'(s2_prod_ff[15:12]) * 11'd100;
   assign s3_rem_in = 7'(11'(s2_rem_ff) - hu_base);

   assign s4_prod_in = 15'(s3_rem_ff) * 15'(RECIP_10);

   always_comb begin
      te_dig                = s4_prod_ff[14:11];
      te_base               = 8'(te_dig) * 8'd10;
      s5_item_in.error      = s4_err_ff;
      s5_item_in.digit[PLACE_THOUSANDS] = {2'b00, s4_th_ff};
      s5_item_in.digit[PLACE_HUNDREDS]  = s4_hu_ff;
      s5_item_in.digit[PLACE_TENS]      = te_dig;
      s5_item_in.digit[PLACE_ONES]      = 4'(8'(s4_rem_ff) - te_base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         s1_err_ff <= s1_err_in;
         s1_th_ff  <= s1_th_in;
         s1_rem_ff <= s1_rem_in;
      end
      if (ld[1]) begin
         s2_err_ff  <= s1_err_ff;
         s2_th_ff   <= s1_th_ff;
         s2_rem_ff  <= s1_rem_ff;
         s2_prod_ff <= s2_prod_in;
      end
      if (ld[2]) begin
         s3_err_ff <= s2_err_ff;
         s3_th_ff  <= s2_th_ff;
         s3_hu_ff  <= s2_prod_ff[15:12];
         s3_rem_ff <= s3_rem_in;
      end
      if (ld[3]) begin
         s4_err_ff  <= s3_err_ff;
         s4_th_ff   <= s3_th_ff;
         s4_hu_ff   <= s3_hu_ff;
         s4_rem_ff  <= s3_rem_ff;
         s4_prod_ff <= s4_prod_in;
      end
      if (ld[4]) begin
         s5_item_ff <= s5_item_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_item  = s5_item_ff;

endmodule

[hw/rtl/i2r_emit.sv]
// letter emitter: walks the digit patterns of one item, one letter per transaction
// depends on i2r_pkg
module i2r_emit import i2r_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  item_type            in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [CHAR_W-1:0]   out_char,
   output logic                out_last,
   output logic                out_error
);

   typedef struct packed {
      logic       found;
      logic [1:0] place;
   } srch_type;

   // highest place below limit whose digit is non-zero
   function automatic srch_type first_nz(input logic [PLACES-1:0][DIGIT_W-1:0] d,
                                         input logic [2:0] limit);
      srch_type r;
      r = '0;
      for (int p = 0; p < PLACES; p++) begin
         if ((3'(p) < limit) && (d[p] != '0)) begin
            r.found = 1'b1;
            r.place = 2'(p);
         end
      end
      return r;
   endfunction

   logic        valid_ff, valid_in;
   item_type    item_ff, item_in;
   logic [1:0]  place_ff, place_in;
   logic [1:0]  pos_ff, pos_in;

   logic [DIGIT_W-1:0] cur_digit;
   logic [2:0]         cur_len;
   logic               more;
   srch_type           nxt;
   srch_type           start;
   logic               load;
   logic               advance;

   always_comb begin
      cur_digit = item_ff.digit[place_ff];
      cur_len   = shape_len(cur_digit);
      more      = (3'({1'b0, pos_ff}) + 3'd1) < cur_len;
      nxt       = first_nz(item_ff.digit, {1'b0, place_ff});
      start     = first_nz(in_item.digit, 3'd4);
   end

   assign out_valid = valid_ff;
   assign out_error = item_ff.error;
   assign out_last  = item_ff.error || (!more && !nxt.found);
   assign out_char  = item_ff.error ? ASCII_NUL
                                    : letter(place_ff, shape_sym(cur_digit, pos_ff));

   assign advance  = valid_ff && out_ready;
   assign in_ready = !valid_ff || (out_ready && out_last);
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      place_in = place_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = in_item;
         place_in = start.place;
         pos_in   = 2'd0;
      end else if (advance) begin
         if (out_last) begin
            valid_in = 1'b0;
         end else if (more) begin
            pos_in = pos_ff + 2'd1;
         end else begin
            place_in = nxt.place;
            pos_in   = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      place_ff <= place_in;
      pos_ff   <= pos_in;
   end

endmodule

[hw/rtl/integer_to_roman_numeral.sv]
// roman numeral encoder: a request passes the five split stages and the emitter register
// before its first letter shows; throughput: one letter per cycle while rsp_tready is high
// an item holds the emitter for its 1 to 15 letters, or a single null for a bad value
// the five-stage digit split holds up to five transactions while the emitter is busy
// reset is synchronous and active high; it empties all pipeline stages and the emitter
// depends on i2r_pkg, i2r_split and i2r_emit
module integer_to_roman_numeral import i2r_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,   // [11:0] value, [15:12] zero
   // response channel, one letter per transaction
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,   // [6:0] character, [7] zero
   output logic                    rsp_tlast,   // final letter of the numeral
   output logic                    rsp_tuser    // [0] error: value zero or above 3999
);

   // digit split to emitter hand-off
   logic               split_valid;
   logic               split_ready;
   item_type           split_item;
   logic [CHAR_W-1:0]  rsp_char;

   // range check and decimal split, one register stage per dependent step
   i2r_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_value  (req_tdata[VALUE_W-1:0]),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_item  (split_item)
   );

   // letter emitter holds the item being spelt out and drives the response registers
   i2r_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_item   (split_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_char),
      .out_last  (rsp_tlast),
      .out_error (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, rsp_char};

   // an error response is a single transaction carrying a null character
   a_err_single : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && (rsp_char == ASCII_NUL)))
      else $error("error response not a single null letter");

   // a valid numeral never emits a null character
   a_letter_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_char != ASCII_NUL))
      else $error("null character inside a numeral");

   // the emitter only takes a new item once the previous numeral has finished
   a_handoff : assert property (@(posedge clock) disable iff (reset)
      (split_ready && rsp_tvalid) |-> (rsp_tready && rsp_tlast))
      else $error("emitter reloaded mid numeral");

endmodule
